@@ design/ctb_pkg.sv @@
// ----------------------------------------------------------------------------
// ctb_pkg
// shared types and constants of the countdown timer bank
// ----------------------------------------------------------------------------
package ctb_pkg;

    localparam int MAX_SLOTS     = 8;
    localparam int NUM_SLOTS_DEF = 8;
    localparam int CNT_W         = 32;
    localparam int DIV_W         = 16;
    localparam int SLOT_IDX_W    = 8;
    localparam int CFG_IDX_W     = 1;
    localparam int CFG_DATA_W    = 32;

    localparam logic [CNT_W-1:0] TICK_INC_RESET = 32'd1;
    localparam logic [DIV_W-1:0] DIVIDER_RESET  = 16'd1000;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_TICK_INC      = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TICKS_PER_SEC = 1'd1;

    typedef enum logic [1:0] {
        MODE_TICK  = 2'd0,
        MODE_START = 2'd1,
        MODE_STOP  = 2'd2
    } t_mode;

    typedef struct packed {
        logic [1:0]            mode;
        logic [SLOT_IDX_W-1:0] slot;
        logic [CNT_W-1:0]      start_count;
        logic [CNT_W-1:0]      reload_count;
        logic                  notify;
    } t_item;

    typedef struct packed {
        logic [CNT_W-1:0]     tick_ms;
        logic [MAX_SLOTS-1:0] expired_mask;
        logic                 second_pulse;
        logic [CNT_W-1:0]     seconds_count;
        logic                 slot_error;
    } t_result;

    // controller to datapath
    typedef struct packed {
        logic exec;
    } t_ctrl_cmd;

endpackage

@@ design/ctb_item_if.sv @@
// ----------------------------------------------------------------------------
// ctb_item_if
// input channel: tick, start or stop items
// ----------------------------------------------------------------------------
interface ctb_item_if;
    logic        valid;
    logic        ready;
    logic [1:0]  mode;
    logic [7:0]  slot;
    logic [31:0] start_count;
    logic [31:0] reload_count;
    logic        notify;

    modport source (output valid, mode, slot, start_count, reload_count, notify,
                    input ready);
    modport sink   (input valid, mode, slot, start_count, reload_count, notify,
                    output ready);
endinterface

@@ design/ctb_result_if.sv @@
// ----------------------------------------------------------------------------
// ctb_result_if
// output channel: one result per item
// ----------------------------------------------------------------------------
interface ctb_result_if;
    logic        valid;
    logic        ready;
    logic [31:0] tick_ms;
    logic [7:0]  expired_mask;
    logic        second_pulse;
    logic [31:0] seconds_count;
    logic        slot_error;

    modport source (output valid, tick_ms, expired_mask, second_pulse,
                    seconds_count, slot_error, input ready);
    modport sink   (input valid, tick_ms, expired_mask, second_pulse,
                    seconds_count, slot_error, output ready);
endinterface

@@ design/ctb_ctrl.sv @@
// ----------------------------------------------------------------------------
// ctb_ctrl
// output register occupancy and input handshake control
// ----------------------------------------------------------------------------
module ctb_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output ctb_pkg::t_ctrl_cmd o_cmd
);

    typedef enum logic {
        S_EMPTY,
        S_FULL
    } t_state;

    t_state r_state;
    t_state n_state;

    // a new item may enter when the result register is free or drains now
    assign o_in_ready  = i_rst_n && ((r_state == S_EMPTY) || i_out_ready);
    assign o_cmd.exec  = i_in_valid && o_in_ready;
    assign o_out_valid = (r_state == S_FULL);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_EMPTY: begin
                if (o_cmd.exec) n_state = S_FULL;
            end
            S_FULL: begin
                if (o_cmd.exec)       n_state = S_FULL;
                else if (i_out_ready) n_state = S_EMPTY;
            end
            default: n_state = S_EMPTY;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_EMPTY;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

@@ design/ctb_datapath.sv @@
// ----------------------------------------------------------------------------
// ctb_datapath
// slot lanes, ms counter, seconds divider and result register
// ----------------------------------------------------------------------------
module ctb_datapath #(
    parameter int NUM_SLOTS = ctb_pkg::NUM_SLOTS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  ctb_pkg::t_ctrl_cmd                 i_cmd,
    input  ctb_pkg::t_item                     i_item,
    input  logic                               i_cfg_we,
    input  logic [ctb_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [ctb_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    output ctb_pkg::t_result                   o_result
);

    localparam int CW = ctb_pkg::CNT_W;
    localparam int DW = ctb_pkg::DIV_W;

    ctb_pkg::t_mode w_mode;

    logic [CW-1:0] r_tick_inc;
    logic [DW-1:0] r_tps;
    logic [CW-1:0] r_ms_counter, n_ms_counter;
    logic [DW-1:0] r_sec_div, n_sec_div;
    logic [CW-1:0] r_sec_count, n_sec_count;

    logic [NUM_SLOTS-1:0]         r_active, n_active;
    logic [NUM_SLOTS-1:0]         r_notify, n_notify;
    logic [NUM_SLOTS-1:0][CW-1:0] r_count, n_count;
    logic [NUM_SLOTS-1:0][CW-1:0] r_reload, n_reload;

    ctb_pkg::t_result r_result, n_result;

    logic                          w_slot_hit;
    logic [ctb_pkg::MAX_SLOTS-1:0] w_expired;
    logic                          w_pulse;
    logic                          w_err;

    assign w_mode     = ctb_pkg::t_mode'(i_item.mode);
    assign w_slot_hit = (i_item.slot < ctb_pkg::SLOT_IDX_W'(NUM_SLOTS));

    always_comb begin
        n_ms_counter = r_ms_counter;
        n_sec_div    = r_sec_div;
        n_sec_count  = r_sec_count;
        n_active     = r_active;
        n_notify     = r_notify;
        n_count      = r_count;
        n_reload     = r_reload;
        w_expired    = '0;
        w_pulse      = 1'b0;
        w_err        = 1'b0;

        unique case (w_mode)
            ctb_pkg::MODE_TICK: begin
                n_ms_counter = r_ms_counter + r_tick_inc;
                // every slot lane steps in parallel
                for (int i = 0; i < NUM_SLOTS; i++) begin
                    if (r_active[i] && (r_count[i] != '0)) begin
                        if (r_count[i] == CW'(1)) begin
                            w_expired[i] = r_notify[i];
                            if (r_reload[i] != '0) n_count[i] = r_reload[i];
                            else begin
                                n_count[i]  = '0;
                                n_active[i] = 1'b0;
                            end
                        end else begin
                            n_count[i] = r_count[i] - CW'(1);
                        end
                    end
                end
                // divider at zero wraps, giving a 65536 tick period
                if (r_sec_div == DW'(1)) begin
                    w_pulse     = 1'b1;
                    n_sec_count = r_sec_count + CW'(1);
                    n_sec_div   = r_tps;
                end else begin
                    n_sec_div = r_sec_div - DW'(1);
                end
            end
            ctb_pkg::MODE_START: begin
                if (!w_slot_hit) w_err = 1'b1;
                for (int i = 0; i < NUM_SLOTS; i++) begin
                    if (i_item.slot == ctb_pkg::SLOT_IDX_W'(i)) begin
                        n_count[i]  = i_item.start_count;
                        n_reload[i] = i_item.reload_count;
                        n_notify[i] = i_item.notify;
                        n_active[i] = 1'b1;
                    end
                end
            end
            ctb_pkg::MODE_STOP: begin
                for (int i = 0; i < NUM_SLOTS; i++) begin
                    if (i_item.slot == ctb_pkg::SLOT_IDX_W'(i)) n_active[i] = 1'b0;
                end
            end
            default: begin
            end
        endcase

        n_result.tick_ms       = n_ms_counter;
        n_result.expired_mask  = w_expired;
        n_result.second_pulse  = w_pulse;
        n_result.seconds_count = n_sec_count;
        n_result.slot_error    = w_err;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tick_inc   <= ctb_pkg::TICK_INC_RESET;
            r_tps        <= ctb_pkg::DIVIDER_RESET;
            r_ms_counter <= '0;
            r_sec_div    <= ctb_pkg::DIVIDER_RESET;
            r_sec_count  <= '0;
            r_active     <= '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    ctb_pkg::CFG_TICK_INC:      r_tick_inc <= i_cfg_data;
                    ctb_pkg::CFG_TICKS_PER_SEC: r_tps      <= i_cfg_data[DW-1:0];
                    default: begin
                    end
                endcase
            end
            if (i_cmd.exec) begin
                r_ms_counter <= n_ms_counter;
                r_sec_div    <= n_sec_div;
                r_sec_count  <= n_sec_count;
                r_active     <= n_active;
            end
        end
    end

    // slot payload is only read while its active bit is set
    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            r_notify <= n_notify;
            r_count  <= n_count;
            r_reload <= n_reload;
            r_result <= n_result;
        end
    end

    assign o_result = r_result;

    a_ms_only_on_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.exec && w_mode != ctb_pkg::MODE_TICK) |=> $stable(r_ms_counter))
        else $error("ms counter moved on a non-tick item");

    a_div_only_on_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.exec && w_mode != ctb_pkg::MODE_TICK)
            |=> ($stable(r_sec_div) && $stable(r_sec_count)))
        else $error("seconds divider moved on a non-tick item");

    a_active_set_by_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_cmd.exec && w_mode == ctb_pkg::MODE_START)
            |=> ((r_active & ~$past(r_active)) == '0))
        else $error("slot became active without a start");

    a_flags_only_on_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.exec && w_mode != ctb_pkg::MODE_TICK)
            |=> (r_result.expired_mask == '0 && !r_result.second_pulse))
        else $error("expiry or pulse flagged on a non-tick item");

    a_error_only_on_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.exec && w_mode != ctb_pkg::MODE_START) |=> !r_result.slot_error)
        else $error("slot error flagged on a non-start item");

endmodule

@@ design/countdown_timer_bank_core.sv @@
// ----------------------------------------------------------------------------
// countdown_timer_bank_core
// bank of countdown timer slots with ms counter and seconds divider
// ----------------------------------------------------------------------------
// a result is valid in the cycle after its item is accepted
// throughput: one item per cycle while results are taken; all slot lanes update in the accept cycle
// the result register frees while it is read, so input ready stays high
// whenever the output side takes the pending transaction
// reset (synchronous, active low): slots inactive, ms and seconds counters zero, divider and
// ticks_per_second 1000, tick_increment 1, no result pending
module countdown_timer_bank_core #(
    parameter int NUM_SLOTS = ctb_pkg::NUM_SLOTS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // configuration write port
    input  logic                           i_cfg_we,
    input  logic [ctb_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [ctb_pkg::CFG_DATA_W-1:0] i_cfg_data,
    // item and result channels
    ctb_item_if.sink                       i_item,
    ctb_result_if.source                   o_result
);

    ctb_pkg::t_ctrl_cmd w_cmd;
    ctb_pkg::t_item     w_item;
    ctb_pkg::t_result   w_result;
    logic               w_in_ready;
    logic               w_out_valid;

    // pack the incoming transaction payload
    assign w_item.mode         = i_item.mode;
    assign w_item.slot         = i_item.slot;
    assign w_item.start_count  = i_item.start_count;
    assign w_item.reload_count = i_item.reload_count;
    assign w_item.notify       = i_item.notify;

    // handshake control: tracks whether the result register holds a result
    ctb_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_item.valid),
        .o_in_ready  (w_in_ready),
        .o_out_valid (w_out_valid),
        .i_out_ready (o_result.ready),
        .o_cmd       (w_cmd)
    );

    // slot lanes, counters and the result register
    ctb_datapath #(
        .NUM_SLOTS (NUM_SLOTS)
    ) u_datapath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (w_cmd),
        .i_item     (w_item),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_result   (w_result)
    );

    assign i_item.ready = w_in_ready;

    // drive the outgoing transaction
    assign o_result.valid         = w_out_valid;
    assign o_result.tick_ms       = w_result.tick_ms;
    assign o_result.expired_mask  = w_result.expired_mask;
    assign o_result.second_pulse  = w_result.second_pulse;
    assign o_result.seconds_count = w_result.seconds_count;
    assign o_result.slot_error    = w_result.slot_error;

endmodule
